// ===== hdl/clp_pkg.sv =====
// shared constants, types and codes for the coordinate line parser
`default_nettype none
package clp_pkg;

  // sizing
  localparam int LINE_LIMIT = 128;
  localparam int COORD_BITS = 16;
  localparam int CNT_W      = $clog2(LINE_LIMIT);
  localparam int OUT_W      = 16;
  localparam int CMP_W      = (COORD_BITS > OUT_W) ? COORD_BITS : OUT_W;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // register indexes
  localparam logic REG_MAX_X = 1'b0;
  localparam logic REG_MAX_Y = 1'b1;

  // characters
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_Y     = 8'h59;

  // matcher phases
  localparam logic [2:0] PH_NONE   = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_SIGN   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [2:0]            phase;
    logic [COORD_BITS-1:0] value;
    logic                  neg;
    logic                  ovf;
  } match_t;

  typedef struct packed {
    logic       feed;
    logic       clear;
    logic [7:0] ch;
    logic [7:0] prev;
  } feed_t;

endpackage
`default_nettype wire

// ===== hdl/clp_ifs.sv =====
// valid/ready channels for received bytes and parse results
`default_nettype none
interface clp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface clp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] coord_x;
  logic [15:0] coord_y;
  modport source (output valid, output status, output coord_x, output coord_y, input ready);
  modport sink (input valid, input status, input coord_x, input coord_y, output ready);
endinterface
`default_nettype wire

// ===== hdl/clp_cfg.sv =====
// apb register bank holding the coordinate limits
`default_nettype none
module clp_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [clp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [clp_pkg::DATA_W-1:0]  pwdata,
  output logic      [clp_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic      [clp_pkg::OUT_W-1:0]   max_x_o,
  output logic      [clp_pkg::OUT_W-1:0]   max_y_o
);
  import clp_pkg::*;

  logic [OUT_W-1:0] max_x_q, max_y_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= '1;
      max_y_q <= '1;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MAX_X: max_x_q <= pwdata[OUT_W-1:0];
        REG_MAX_Y: max_y_q <= pwdata[OUT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_X: prdata = {{(DATA_W-OUT_W){1'b0}}, max_x_q};
      REG_MAX_Y: prdata = {{(DATA_W-OUT_W){1'b0}}, max_y_q};
      default:   prdata = '0;
    endcase
  end

  assign max_x_o = max_x_q;
  assign max_y_o = max_y_q;
endmodule
`default_nettype wire

// ===== hdl/clp_matcher.sv =====
// one "<letter>=" matcher with atoi-style value accumulation
`default_nettype none
module clp_matcher (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      letter_i,
  input  wire clp_pkg::feed_t  feed_i,
  output clp_pkg::match_t      state_o
);
  import clp_pkg::*;

  match_t                state_q, state_d;
  logic                  digit, space;
  logic [3:0]            dval;
  logic [COORD_BITS+3:0] acc;

  assign digit = (feed_i.ch >= CHAR_ZERO) && (feed_i.ch <= CHAR_NINE);
  assign space = (feed_i.ch == CHAR_SPACE) ||
                 ((feed_i.ch >= CHAR_TAB) && (feed_i.ch <= CHAR_CR));
  assign dval  = 4'(feed_i.ch - CHAR_ZERO);

  // value * 10 + digit as shifts
  assign acc = ({4'b0, state_q.value} << 3) + ({4'b0, state_q.value} << 1) +
               {{COORD_BITS{1'b0}}, dval};

  always_comb begin
    state_d = state_q;
    if (feed_i.clear) begin
      state_d = '0;
      state_d.phase = PH_NONE;
    end else if (feed_i.feed) begin
      case (state_q.phase)
        PH_NONE: begin
          if (feed_i.prev == letter_i && feed_i.ch == CHAR_EQ) state_d.phase = PH_SPACE;
        end
        PH_SPACE: begin
          if (space) begin
            state_d.phase = PH_SPACE;
          end else if (feed_i.ch == CHAR_PLUS || feed_i.ch == CHAR_MINUS) begin
            if (feed_i.ch == CHAR_MINUS) state_d.neg = 1'b1;
            state_d.phase = PH_SIGN;
          end else if (digit) begin
            state_d.value = {{(COORD_BITS-4){1'b0}}, dval};
            state_d.phase = PH_DIGITS;
          end else begin
            state_d.phase = PH_DONE;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (digit) begin
            if (!state_q.ovf) begin
              // saturate once the magnitude leaves the coordinate width
              if (acc[COORD_BITS+3:COORD_BITS] != 4'd0) begin
                state_d.value = '1;
                state_d.ovf   = 1'b1;
              end else begin
                state_d.value = acc[COORD_BITS-1:0];
              end
            end
            state_d.phase = PH_DIGITS;
          end else begin
            state_d.phase = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;
endmodule
`default_nettype wire

// ===== hdl/coordinate_line_parser_top.sv =====
// coordinate line parser: byte intake, line bookkeeping, verdict and result register
// result timing: the result of a newline byte accepted at a clock edge is registered and shows valid after that edge;
//   other bytes give no result and only update the running line state
// throughput: one byte per cycle; only a full, unclaimed result register stalls intake
// reset: asynchronous active low; clears line state and result valid, limits go to 65535
`default_nettype none
module coordinate_line_parser_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  clp_rx_if.sink                           rx_i,
  clp_res_if.source                        res_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [clp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [clp_pkg::DATA_W-1:0]  pwdata,
  output logic      [clp_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import clp_pkg::*;

  // limit registers
  logic [OUT_W-1:0] max_x, max_y;

  clp_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .max_x_o (max_x),
    .max_y_o (max_y)
  );

  // request handshake on the byte side
  logic rx_acc, is_nl, keep, feed;
  logic out_valid_q;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign rx_acc     = rx_i.valid && rx_i.ready;
  assign is_nl      = rx_i.rx_byte == CHAR_NL;

  // line bookkeeping: stored count, nul latch, previous kept character
  logic [CNT_W-1:0] count_q;
  logic             nul_q;
  logic [7:0]       prev_q;

  assign keep = count_q < CNT_W'(LINE_LIMIT - 1);
  // a byte reaches the matchers only if kept, before any nul, and not nul itself
  assign feed = rx_acc && !is_nl && keep && !nul_q && rx_i.rx_byte != CHAR_NUL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      nul_q   <= 1'b0;
      prev_q  <= CHAR_NUL;
    end else if (rx_acc) begin
      if (is_nl) begin
        count_q <= '0;
        nul_q   <= 1'b0;
        prev_q  <= CHAR_NUL;
      end else if (keep) begin
        count_q <= count_q + CNT_W'(1);
        if (!nul_q) begin
          if (rx_i.rx_byte == CHAR_NUL) nul_q  <= 1'b1;
          else                          prev_q <= rx_i.rx_byte;
        end
      end
    end
  end

  // the two pattern matchers share one feed request
  feed_t  fd;
  match_t mx, my;

  assign fd.feed  = feed;
  assign fd.clear = rx_acc && is_nl;
  assign fd.ch    = rx_i.rx_byte;
  assign fd.prev  = prev_q;

  clp_matcher u_mx (.clk_i, .rst_ni, .letter_i(CHAR_X), .feed_i(fd), .state_o(mx));
  clp_matcher u_my (.clk_i, .rst_ni, .letter_i(CHAR_Y), .feed_i(fd), .state_o(my));

  // verdict on the state before this newline clears it
  logic [CMP_W-1:0] vx, vy;
  logic             x_ok, y_ok;
  logic [1:0]       status_d;
  logic [OUT_W-1:0] cx_d, cy_d;

  assign vx = CMP_W'(mx.value);
  assign vy = CMP_W'(my.value);
  // negative is fine only for a zero magnitude; overflow never passes
  assign x_ok = !mx.ovf && !(mx.neg && vx != '0) && vx <= CMP_W'(max_x);
  assign y_ok = !my.ovf && !(my.neg && vy != '0) && vy <= CMP_W'(max_y);

  always_comb begin
    cx_d = '0;
    cy_d = '0;
    if (mx.phase == PH_NONE || my.phase == PH_NONE) begin
      status_d = ST_MISSING;
    end else if (x_ok && y_ok) begin
      status_d = ST_OK;
      cx_d     = vx[OUT_W-1:0];
      cy_d     = vy[OUT_W-1:0];
    end else begin
      status_d = ST_RANGE;
    end
  end

  // result register, takes a newline's result when empty or when the old one is claimed this cycle
  logic [1:0]       status_q;
  logic [OUT_W-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_acc && is_nl) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_acc && is_nl) begin
      status_q <= status_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.status  = status_q;
  assign res_o.coord_x = cx_q;
  assign res_o.coord_y = cy_q;

  // a new result only follows an accepted newline
  a_rose_after_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(rx_acc && is_nl))
    else $error("result appeared without a newline");

  // a rejected line never carries coordinates
  a_zero_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != ST_OK) |-> (res_o.coord_x == '0 && res_o.coord_y == '0))
    else $error("coordinates on rejected line");

  // status stays within its defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.status == ST_OK || res_o.status == ST_MISSING ||
                     res_o.status == ST_RANGE))
    else $error("undefined status code");

  // newline leaves both matchers and the line count cleared
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_acc && is_nl) |=> (mx.phase == PH_NONE && my.phase == PH_NONE && count_q == '0))
    else $error("line state not cleared");
endmodule
`default_nettype wire
